// ===== hdl/iirdf1_pkg.sv =====
// shared types, constants and microcode table for the direct-form i iir filter
package iirdf1_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEFF_W     = 16;
   localparam int COEFF_LANES = 8;
   localparam int BANK_W      = COEFF_W * COEFF_LANES;
   localparam int REG_W       = 64;
   localparam int MAX_ORDER   = 7;
   localparam int TAP_W       = 3;
   localparam int COUNT_W     = 3;
   localparam int PROD_W      = SAMPLE_W + COEFF_W;
   localparam int ACC_W       = 40;
   localparam int FRAC_SHIFT  = 14;
   localparam int QUOT_W      = ACC_W - FRAC_SHIFT;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W      = 5;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

   // register map
   localparam logic [CSR_INDEX_W-1:0] REG_FF_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FF_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FF_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_HIGH  = 3'd5;

   localparam logic [REG_W-1:0] FF_LOW_RESET = 64'd16384;

   // program addresses
   localparam logic [STEP_W-1:0] STEP_X        = 5'd0;
   localparam logic [STEP_W-1:0] STEP_FB_FIRST = 5'd8;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 5'd15;
   localparam logic [STEP_W-1:0] STEP_FINISH   = 5'd16;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MAC_X,
      OP_MAC_FF,
      OP_MAC_FB,
      OP_DRAIN,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_FF,
      COND_FB
   } cond_type;

   typedef struct packed {
      op_type              op;
      logic [TAP_W-1:0]    tap;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   typedef struct packed {
      op_type              op;
      logic [TAP_W-1:0]    tap;
   } exec_type;

   // control store: one word per step
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{op: OP_NOP, tap: '0, cond: COND_NONE, target: '0};
      unique case (step)
         5'd0:  w = '{OP_MAC_X,  3'd0, COND_NONE, STEP_FB_FIRST};
         5'd1:  w = '{OP_MAC_FF, 3'd1, COND_FF,   STEP_FB_FIRST};
         5'd2:  w = '{OP_MAC_FF, 3'd2, COND_FF,   STEP_FB_FIRST};
         5'd3:  w = '{OP_MAC_FF, 3'd3, COND_FF,   STEP_FB_FIRST};
         5'd4:  w = '{OP_MAC_FF, 3'd4, COND_FF,   STEP_FB_FIRST};
         5'd5:  w = '{OP_MAC_FF, 3'd5, COND_FF,   STEP_FB_FIRST};
         5'd6:  w = '{OP_MAC_FF, 3'd6, COND_FF,   STEP_FB_FIRST};
         5'd7:  w = '{OP_MAC_FF, 3'd7, COND_FF,   STEP_FB_FIRST};
         5'd8:  w = '{OP_MAC_FB, 3'd1, COND_FB,   STEP_DRAIN};
         5'd9:  w = '{OP_MAC_FB, 3'd2, COND_FB,   STEP_DRAIN};
         5'd10: w = '{OP_MAC_FB, 3'd3, COND_FB,   STEP_DRAIN};
         5'd11: w = '{OP_MAC_FB, 3'd4, COND_FB,   STEP_DRAIN};
         5'd12: w = '{OP_MAC_FB, 3'd5, COND_FB,   STEP_DRAIN};
         5'd13: w = '{OP_MAC_FB, 3'd6, COND_FB,   STEP_DRAIN};
         5'd14: w = '{OP_MAC_FB, 3'd7, COND_FB,   STEP_DRAIN};
         5'd15: w = '{OP_DRAIN,  3'd0, COND_NONE, STEP_FINISH};
         5'd16: w = '{OP_FINISH, 3'd0, COND_NONE, STEP_X};
         default: w = '{OP_FINISH, 3'd0, COND_NONE, STEP_X};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/iirdf1_if.sv =====
// channel interfaces: sample request, filtered response, register write
interface iirdf1_req_if;
   import iirdf1_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf1_rsp_if;
   import iirdf1_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       clipped;
   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface iirdf1_csr_if;
   import iirdf1_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [REG_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/iir_direct_form_one_filter.sv =====
// top level of the direct-form i iir filter
//
// req_port takes one q1.15 sample per word; rsp_port returns one rounded and
// saturated q1.15 sample per word with a clipped flag; csr_port writes the
// tap counts (index 0, 1) and the packed q2.14 coefficient banks (index 2..5).
// csr_port is always ready; write it only while the filter is idle.
// a sample runs through a microcoded sequencer that drives one shared
// 16x16 multiply-accumulate: step 0 does b0*x, then one step per
// feedforward tap, one per feedback tap, one skip step for each section
// that is shorter than seven taps, one drain step and one finish step.
// the next word can be taken in the cycle after finish; a new sample is
// not accepted while the sequencer still runs the previous one
// the finished word waits in an output register; a stalled receiver only
// holds the finish step of the next sample, which can be accepted meanwhile
// reset clears both delay lines, the counts and the coefficients (b0 = 1.0)
module iir_direct_form_one_filter (
   input  logic            clock,
   input  logic            reset,
   iirdf1_req_if.sink      req_port,
   iirdf1_rsp_if.source    rsp_port,
   iirdf1_csr_if.sink      csr_port
);
   import iirdf1_pkg::*;

   logic               seq_idle;
   logic               start;
   logic               out_free;
   exec_type           exec;
   logic [COUNT_W-1:0] ff_count, fb_count;
   logic [BANK_W-1:0]  ff_coeffs, fb_coeffs;

   // a word is taken only when the sequencer has nothing in flight
   assign req_port.ready = seq_idle;
   assign start          = req_port.valid && seq_idle;

   // register file
   iirdf1_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (csr_port.valid),
      .wr_index  (csr_port.index),
      .wr_data   (csr_port.data),
      .wr_ready  (csr_port.ready),
      .ff_count  (ff_count),
      .fb_count  (fb_count),
      .ff_coeffs (ff_coeffs),
      .fb_coeffs (fb_coeffs)
   );

   // control store walk, jumps past unused taps
   iirdf1_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .ff_count (ff_count),
      .fb_count (fb_count),
      .out_free (out_free),
      .idle     (seq_idle),
      .exec     (exec)
   );

   // shared mac, delay lines and output register
   iirdf1_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sample_in  (req_port.sample_in),
      .exec       (exec),
      .ff_coeffs  (ff_coeffs),
      .fb_coeffs  (fb_coeffs),
      .out_free   (out_free),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .sample_out (rsp_port.sample_out),
      .clipped    (rsp_port.clipped)
   );

endmodule

// ===== hdl/iirdf1_csr.sv =====
// configuration registers: tap counts and packed coefficient banks
module iirdf1_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_valid,
   input  logic [iirdf1_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [iirdf1_pkg::REG_W-1:0]       wr_data,
   output logic                              wr_ready,
   output logic [iirdf1_pkg::COUNT_W-1:0]     ff_count,
   output logic [iirdf1_pkg::COUNT_W-1:0]     fb_count,
   output logic [iirdf1_pkg::BANK_W-1:0]      ff_coeffs,
   output logic [iirdf1_pkg::BANK_W-1:0]      fb_coeffs
);
   import iirdf1_pkg::*;

   logic [COUNT_W-1:0] nb_ff, nb_in, na_ff, na_in;
   logic [REG_W-1:0]   ffl_ff, ffl_in, ffh_ff, ffh_in, fbl_ff, fbl_in, fbh_ff, fbh_in;

   always_comb begin
      nb_in  = nb_ff;
      na_in  = na_ff;
      ffl_in = ffl_ff;
      ffh_in = ffh_ff;
      fbl_in = fbl_ff;
      fbh_in = fbh_ff;
      if (wr_valid) begin
         unique case (wr_index)
            REG_FF_COUNT: nb_in  = wr_data[COUNT_W-1:0];
            REG_FB_COUNT: na_in  = wr_data[COUNT_W-1:0];
            REG_FF_LOW:   ffl_in = wr_data;
            REG_FF_HIGH:  ffh_in = wr_data;
            REG_FB_LOW:   fbl_in = wr_data;
            REG_FB_HIGH:  fbh_in = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff  <= '0;
         na_ff  <= '0;
         ffl_ff <= FF_LOW_RESET;
         ffh_ff <= '0;
         fbl_ff <= '0;
         fbh_ff <= '0;
      end else begin
         nb_ff  <= nb_in;
         na_ff  <= na_in;
         ffl_ff <= ffl_in;
         ffh_ff <= ffh_in;
         fbl_ff <= fbl_in;
         fbh_ff <= fbh_in;
      end
   end

   assign wr_ready  = 1'b1;
   assign ff_count  = nb_ff;
   assign fb_count  = na_ff;
   assign ff_coeffs = {ffh_ff, ffl_ff};
   assign fb_coeffs = {fbh_ff, fbl_ff};

endmodule

// ===== hdl/iirdf1_sequencer.sv =====
// step counter and control store walk with tap-count jumps
module iirdf1_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [iirdf1_pkg::COUNT_W-1:0] ff_count,
   input  logic [iirdf1_pkg::COUNT_W-1:0] fb_count,
   input  logic                          out_free,
   output logic                          idle,
   output iirdf1_pkg::exec_type          exec
);
   import iirdf1_pkg::*;

   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         word;
   logic              skip;

   always_comb begin
      word = ucode(step_ff);
      skip = ((word.cond == COND_FF) && (word.tap > ff_count)) ||
             ((word.cond == COND_FB) && (word.tap > fb_count));
      state_in = state_ff;
      step_in  = step_ff;
      exec     = '{op: OP_NOP, tap: word.tap};
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = STEP_X;
            end
         end
         SEQ_RUN: begin
            if (word.op == OP_FINISH) begin
               // hold on the last step until the output register is free
               if (out_free) begin
                  exec.op  = OP_FINISH;
                  state_in = SEQ_IDLE;
                  step_in  = word.target;
               end
            end else if (skip) begin
               step_in = word.target;
            end else begin
               exec.op = word.op;
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= STEP_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign idle = (state_ff == SEQ_IDLE);

endmodule

// ===== hdl/iirdf1_datapath.sv =====
// delay lines, shared multiplier, accumulator, rounding and output register
module iirdf1_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_in,
   input  iirdf1_pkg::exec_type                exec,
   input  logic [iirdf1_pkg::BANK_W-1:0]        ff_coeffs,
   input  logic [iirdf1_pkg::BANK_W-1:0]        fb_coeffs,
   output logic                                out_free,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out,
   output logic                                clipped
);
   import iirdf1_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] xh_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] yh_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] xh_in [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] yh_in [MAX_ORDER];
   logic signed [COEFF_W-1:0]  ff_lane [COEFF_LANES];
   logic signed [COEFF_W-1:0]  fb_lane [COEFF_LANES];
   logic [TAP_W-1:0]           hist_idx;
   logic signed [COEFF_W-1:0]  coef;
   logic signed [SAMPLE_W-1:0] operand;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       pvalid_ff, pvalid_in, psub_ff, psub_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]           rounded;
   logic [QUOT_W-1:0]          quot;
   logic [QUOT_W-SAMPLE_W:0]   upper;
   logic                       over;
   logic signed [SAMPLE_W-1:0] y;
   logic                       finish;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_out_ff, sample_out_in;
   logic                       clipped_ff, clipped_in;

   always_comb begin
      for (int i = 0; i < COEFF_LANES; i++) begin
         ff_lane[i] = ff_coeffs[i*COEFF_W +: COEFF_W];
         fb_lane[i] = fb_coeffs[i*COEFF_W +: COEFF_W];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      hist_idx  = exec.tap - 1'b1;
      coef      = '0;
      operand   = '0;
      pvalid_in = 1'b0;
      psub_in   = 1'b0;
      case (exec.op)
         OP_MAC_X: begin
            coef      = ff_lane[exec.tap];
            operand   = x_ff;
            pvalid_in = 1'b1;
         end
         OP_MAC_FF: begin
            coef      = ff_lane[exec.tap];
            operand   = xh_ff[hist_idx];
            pvalid_in = 1'b1;
         end
         OP_MAC_FB: begin
            coef      = fb_lane[hist_idx];
            operand   = yh_ff[hist_idx];
            pvalid_in = 1'b1;
            psub_in   = 1'b1;
         end
         default: ;
      endcase
      prod_in = coef * operand;
   end

   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (pvalid_ff) begin
         if (psub_ff) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // round half up to q1.15, then saturate
   always_comb begin
      rounded = acc_ff + ROUND_HALF;
      quot    = rounded[ACC_W-1:FRAC_SHIFT];
      upper   = quot[QUOT_W-1:SAMPLE_W-1];
      over    = !((&upper) || !(|upper));
      if (over) begin
         y = quot[QUOT_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         y = quot[SAMPLE_W-1:0];
      end
   end

   assign finish   = (exec.op == OP_FINISH);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      x_in          = start ? sample_in : x_ff;
      xh_in         = xh_ff;
      yh_in         = yh_ff;
      sample_out_in = sample_out_ff;
      clipped_in    = clipped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (finish) begin
         for (int i = MAX_ORDER - 1; i > 0; i--) begin
            xh_in[i] = xh_ff[i-1];
            yh_in[i] = yh_ff[i-1];
         end
         xh_in[0]      = x_ff;
         yh_in[0]      = y;
         sample_out_in = y;
         clipped_in    = over;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff    <= 1'b0;
         psub_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         pvalid_ff    <= pvalid_in;
         psub_ff      <= psub_in;
         rsp_valid_ff <= rsp_valid_in;
         xh_ff        <= xh_in;
         yh_ff        <= yh_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sample_out_ff <= sample_out_in;
      clipped_ff    <= clipped_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign sample_out = sample_out_ff;
   assign clipped    = clipped_ff;

endmodule

// ===== test/tb_iir_direct_form_one_filter.sv =====
// testbench for the direct-form i iir filter: predicted samples checked word by word
module tb_iir_direct_form_one_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import iirdf1_pkg::*;

   // run shape
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_NS     = 5_000_000;  // far above a slow run
   localparam int REPORT_LIMIT    = 10;

   // the map stops at index 5, these two must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));
   localparam longint ROUND_BIAS = longint'(1) << (FRAC_SHIFT - 1);

   typedef enum {
      MIX_FULL_ORDER,   // seven taps each side, any coefficient
      MIX_FIR_ONLY,     // no feedback taps, feedback bank still loaded
      MIX_STABLE,       // small coefficients, output mostly in range
      MIX_ANY           // every register bit random
   } setting_kind_type;

   typedef enum {
      STALL_NONE,
      STALL_CHOPPY,
      STALL_LONG
   } stall_style_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } filtered_word_type;

   // own copy of the filter: registers, both delay lines, the words still owed
   class filtered_sample_tracker;
      logic [COUNT_W-1:0] ff_taps;
      logic [COUNT_W-1:0] fb_taps;
      logic [REG_W-1:0]   ff_low;
      logic [REG_W-1:0]   ff_high;
      logic [REG_W-1:0]   fb_low;
      logic [REG_W-1:0]   fb_high;
      longint             in_line[MAX_ORDER];
      longint             out_line[MAX_ORDER];
      filtered_word_type  pending_words[$];
      int                 mismatches;

      function new();
         ff_taps = '0;
         fb_taps = '0;
         ff_low  = FF_LOW_RESET;
         ff_high = '0;
         fb_low  = '0;
         fb_high = '0;
         foreach (in_line[i]) begin
            in_line[i]  = 0;
            out_line[i] = 0;
         end
         mismatches = 0;
      endfunction

      function void write_register(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [REG_W-1:0] value);
         case (idx)
            REG_FF_COUNT: ff_taps = value[COUNT_W-1:0];
            REG_FB_COUNT: fb_taps = value[COUNT_W-1:0];
            REG_FF_LOW:   ff_low  = value;
            REG_FF_HIGH:  ff_high = value;
            REG_FB_LOW:   fb_low  = value;
            REG_FB_HIGH:  fb_high = value;
            default: ;
         endcase
      endfunction

      // lane n of a low/high register pair, sign extended
      function longint tap_coeff(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                 input int n);
         logic [REG_W-1:0]          bank;
         logic signed [COEFF_W-1:0] c;
         bank = (n < 4) ? lo : hi;
         c = bank[(n % 4) * COEFF_W +: COEFF_W];
         return longint'(c);
      endfunction

      function void take_input(input logic signed [SAMPLE_W-1:0] x);
         longint            acc;
         longint            y;
         filtered_word_type w;
         acc = tap_coeff(ff_low, ff_high, 0) * longint'(x);
         for (int i = 1; i <= int'(ff_taps); i++)
            acc += tap_coeff(ff_low, ff_high, i) * in_line[i-1];
         for (int i = 1; i <= int'(fb_taps); i++)
            acc -= tap_coeff(fb_low, fb_high, i - 1) * out_line[i-1];
         // half lsb up, then floor: halves go toward plus infinity
         y = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
         w.clipped = 1'b0;
         if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            w.clipped = 1'b1;
         end
         if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            w.clipped = 1'b1;
         end
         w.sample = y[SAMPLE_W-1:0];
         // both lines shift on every sample whatever the counts
         for (int i = MAX_ORDER - 1; i > 0; i--) begin
            in_line[i]  = in_line[i-1];
            out_line[i] = out_line[i-1];
         end
         in_line[0]  = longint'(x);
         out_line[0] = y;
         pending_words.push_back(w);
      endfunction

      function void note_failure(input string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_output(input logic signed [SAMPLE_W-1:0] sample,
                                 input logic clipped);
         filtered_word_type w;
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected word: sample %0d clipped %0b",
                                   sample, clipped));
            return;
         end
         w = pending_words.pop_front();
         if (w.sample !== sample || w.clipped !== clipped)
            note_failure($sformatf("mismatch: expected sample %0d clipped %0b, got %0d %0b",
                                   w.sample, w.clipped, sample, clipped));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   iirdf1_req_if req_bus ();
   iirdf1_rsp_if rsp_bus ();
   iirdf1_csr_if csr_bus ();

   filtered_sample_tracker tracker = new();

   // sender burst state, kept across phases
   int burst_left = 0;

   iir_direct_form_one_filter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result words are compared at the rising edge they are taken
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_output(rsp_bus.sample_out, rsp_bus.clipped);
   end

   // receiver: its own stall pattern, in a stall style that is redrawn at random
   initial begin : response_stall
      int              stall_left;
      int              cycle_count;
      stall_style_type stall_style;
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      cycle_count   = 0;
      stall_style   = STALL_NONE;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 300 == 0)
            stall_style = stall_style_type'($urandom_range(0, 2));
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            case (stall_style)
               STALL_CHOPPY: stall_left = ($urandom_range(0, 3) == 0) ?
                                          $urandom_range(1, 3) : 0;
               STALL_LONG:   stall_left = ($urandom_range(0, 9) == 0) ?
                                          $urandom_range(5, 30) : 0;
               default:      stall_left = 0;
            endcase
         end
      end
   end

   // one sample word; a new burst starts after a random gap, sometimes none
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      int gap;
      @(negedge clock);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end
      burst_left--;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= x;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_input(x);
   endtask

   // register write, done only while the filter is idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_register(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // stop sending, collect every owed word, then let the sequencer settle
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // four packed lanes; small lanes stay within +-1/8
   function automatic logic [REG_W-1:0] random_bank(input bit small_lanes);
      logic [REG_W-1:0]   bank;
      logic [COEFF_W-1:0] c;
      for (int n = 0; n < 4; n++) begin
         if (small_lanes) c = COEFF_W'($urandom_range(0, 4095) - 2048);
         else c = COEFF_W'($urandom());
         bank[n * COEFF_W +: COEFF_W] = c;
      end
      return bank;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [SAMPLE_W-1:0] x;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: x = 16'sh7FFF;
               1: x = 16'sh8000;
               2: x = 16'sh0000;
               default: x = 16'shFFFF;
            endcase
         end
         1, 2: x = SAMPLE_W'($urandom_range(0, 511) - 256);
         default: x = SAMPLE_W'($urandom());
      endcase
      return x;
   endfunction

   task automatic configure_setting(input setting_kind_type kind);
      logic [REG_W-1:0] ff_count_word;
      logic [REG_W-1:0] fb_count_word;
      logic [REG_W-1:0] ff_low_word;
      logic             small_lanes;
      // count writes carry junk in the upper bits, only the low three count
      ff_count_word = {$urandom(), $urandom()};
      fb_count_word = {$urandom(), $urandom()};
      small_lanes   = (kind == MIX_STABLE);
      ff_low_word   = random_bank(small_lanes);
      case (kind)
         MIX_FULL_ORDER: begin
            ff_count_word[COUNT_W-1:0] = 3'd7;
            fb_count_word[COUNT_W-1:0] = 3'd7;
         end
         MIX_FIR_ONLY: fb_count_word[COUNT_W-1:0] = 3'd0;
         MIX_STABLE: ff_low_word[COEFF_W-1:0] = COEFF_W'($urandom_range(0, 32767) - 16384);
         default: ;
      endcase
      write_csr(REG_FF_COUNT, ff_count_word);
      write_csr(REG_FB_COUNT, fb_count_word);
      write_csr(REG_FF_LOW, ff_low_word);
      write_csr(REG_FF_HIGH, random_bank(small_lanes));
      write_csr(REG_FB_LOW, random_bank(small_lanes));
      // lane 3 of the high feedback bank is random and must have no effect
      write_csr(REG_FB_HIGH,
                random_bank(small_lanes) ^ {COEFF_W'($urandom_range(0, 65535)), 48'h0});
      if ($urandom_range(0, 2) == 0)
         write_csr(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7,
                   {$urandom(), $urandom()});
   endtask

   initial begin : stimulus
      logic signed [SAMPLE_W-1:0] extreme_samples[7];
      logic signed [SAMPLE_W-1:0] clip_samples[6];
      logic signed [SAMPLE_W-1:0] rounding_samples[6];
      extreme_samples  = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001,
                           16'shFFFF, 16'sh5555, 16'shAAAA};
      clip_samples     = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                           16'sh7FFF, 16'sh0000};
      rounding_samples = '{16'sh0001, 16'shFFFF, 16'sh0003, 16'shFFFD,
                           16'sh7FFF, 16'sh8000};

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting passes samples through unchanged (b0 = 1.0, no taps)
      foreach (extreme_samples[i]) send_sample(extreme_samples[i]);
      wait_idle();

      // every tap at full scale with mixed signs: heavy clipping and
      // a saturated value looping back through the feedback line
      write_csr(REG_FF_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_FB_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_FF_LOW, 64'h8000_7FFF_8000_8000);
      write_csr(REG_FF_HIGH, 64'h7FFF_8000_7FFF_8000);
      write_csr(REG_FB_LOW, 64'h8000_7FFF_8000_7FFF);
      write_csr(REG_FB_HIGH, 64'h7FFF_8000_7FFF_8000);
      write_csr(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_SPARE_7, 64'h0000_0000_0000_0000);
      foreach (clip_samples[i]) send_sample(clip_samples[i]);
      wait_idle();

      // b0 = 0.5 puts odd inputs exactly on a half lsb, counts drop to zero
      // while the delay lines keep their history
      write_csr(REG_FF_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
      write_csr(REG_FB_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
      write_csr(REG_FF_LOW, 64'h0000_0000_0000_2000);
      foreach (rounding_samples[i]) send_sample(rounding_samples[i]);
      wait_idle();

      // random phases; the first two pin the order extremes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) configure_setting(MIX_FULL_ORDER);
         else if (phase == 1) configure_setting(MIX_FIR_ONLY);
         else configure_setting(setting_kind_type'($urandom_range(0, 3)));
         repeat (ITEMS_PER_PHASE) send_sample(random_sample());
         wait_idle();
      end

      if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== iir_direct_form_one_filter.f =====
hdl/iirdf1_pkg.sv
hdl/iirdf1_if.sv
hdl/iirdf1_csr.sv
hdl/iirdf1_sequencer.sv
hdl/iirdf1_datapath.sv
hdl/iir_direct_form_one_filter.sv
test/tb_iir_direct_form_one_filter.sv
